// ===== rtl/core/lscf_pkg.sv =====
// Shared types and constants for the least-squares circle fit block.
// Used by the channel interfaces, the controller and the datapath.
package lscf_pkg;

    localparam int COORD_W        = 16;
    localparam int RAD_W          = 16;
    localparam int STAT_W         = 2;
    localparam int MAX_POINTS_DEF = 1024;

    // Solve arithmetic is exact modulo 2^DW.
    localparam int DW          = 128;
    localparam int GUARD       = 6;
    localparam int MUL_DIGIT   = 8;
    localparam int MUL_STEPS   = DW / MUL_DIGIT;
    localparam int SQ_W        = 64;
    localparam int SQRT_STEPS  = SQ_W / 2;
    localparam int ARG_W       = 4;
    localparam int RF_DEPTH    = 16;

    localparam logic [DW-1:0] CX_LIM   = DW'(32768);
    localparam logic [DW-1:0] CX_MAX   = DW'(32767);
    localparam logic [DW-1:0] FX_LIM   = DW'(1) << (17 + GUARD);
    localparam logic [SQ_W-1:0] RAD_HALF = SQ_W'(1) << (GUARD - 1);
    localparam logic [SQ_W-1:0] RAD_MAX  = SQ_W'((1 << RAD_W) - 1);

    typedef enum logic [STAT_W-1:0] {
        FIT_OK       = 2'd0,
        FIT_SINGULAR = 2'd1,
        FIT_NEGRAD   = 2'd2,
        FIT_OVERFLOW = 2'd3
    } t_fit_status;

    typedef enum logic [4:0] {
        OP_RDA, OP_RDB, OP_SUMA, OP_SUMB, OP_MOVA, OP_MOVB,
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CEN, OP_SHL, OP_WR,
        OP_FLAGD, OP_FLAGQ, OP_SETX, OP_SETY, OP_SQRT, OP_END
    } t_op;

    // Register file addresses
    localparam logic [ARG_W-1:0] RA_SR2 = 4'd0;
    localparam logic [ARG_W-1:0] RA_CXX = 4'd1;
    localparam logic [ARG_W-1:0] RA_CYY = 4'd2;
    localparam logic [ARG_W-1:0] RA_CXY = 4'd3;
    localparam logic [ARG_W-1:0] RA_PX  = 4'd4;
    localparam logic [ARG_W-1:0] RA_PY  = 4'd5;
    localparam logic [ARG_W-1:0] RA_D   = 4'd6;
    localparam logic [ARG_W-1:0] RA_NX  = 4'd7;
    localparam logic [ARG_W-1:0] RA_NY  = 4'd8;
    localparam logic [ARG_W-1:0] RA_FX  = 4'd9;
    localparam logic [ARG_W-1:0] RA_FY  = 4'd10;
    localparam logic [ARG_W-1:0] RA_T1  = 4'd11;
    localparam logic [ARG_W-1:0] RA_Q   = 4'd12;

    // Running-sum selects
    localparam logic [ARG_W-1:0] SS_N   = 4'd0;
    localparam logic [ARG_W-1:0] SS_X   = 4'd1;
    localparam logic [ARG_W-1:0] SS_Y   = 4'd2;
    localparam logic [ARG_W-1:0] SS_XX  = 4'd3;
    localparam logic [ARG_W-1:0] SS_YY  = 4'd4;
    localparam logic [ARG_W-1:0] SS_XY  = 4'd5;
    localparam logic [ARG_W-1:0] SS_XR2 = 4'd6;
    localparam logic [ARG_W-1:0] SS_YR2 = 4'd7;

    // Shift amounts
    localparam logic [ARG_W-1:0] SH_NONE = 4'd0;
    localparam logic [ARG_W-1:0] SH_G    = ARG_W'(GUARD);
    localparam logic [ARG_W-1:0] SH_G1   = ARG_W'(GUARD + 1);
    localparam logic [ARG_W-1:0] SH_2G   = ARG_W'(2 * GUARD);
    localparam logic [ARG_W-1:0] ARG_NONE = 4'd0;

    typedef struct packed {
        t_op              op;
        logic [ARG_W-1:0] arg;
    } t_uop;

    typedef struct packed {
        logic start;
        logic acc;
        t_uop uop;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic acc_busy;
    } t_dp_stat;

endpackage

// ===== rtl/core/lscf_point_if.sv =====
// Point input channel: valid/ready with x, y and the last-point flag.
// Depends on lscf_pkg for the coordinate width.
interface lscf_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [lscf_pkg::COORD_W-1:0] point_x;
    logic signed [lscf_pkg::COORD_W-1:0] point_y;
    logic                                last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

// ===== rtl/core/lscf_fit_if.sv =====
// Fit result channel: valid/ready with center, radius and status.
// Depends on lscf_pkg for the field widths.
interface lscf_fit_if;
    logic                                valid;
    logic                                ready;
    logic signed [lscf_pkg::COORD_W-1:0] center_x;
    logic signed [lscf_pkg::COORD_W-1:0] center_y;
    logic [lscf_pkg::RAD_W-1:0]          radius_out;
    logic [lscf_pkg::STAT_W-1:0]         fit_status;

    modport source (output valid, output center_x, output center_y, output radius_out,
                    output fit_status, input ready);
    modport sink (input valid, input center_x, input center_y, input radius_out,
                  input fit_status, output ready);
endinterface

// ===== rtl/core/lscf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lscf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

// ===== rtl/core/lscf_datapath.sv =====
// Datapath: point accumulator, solve register file, shared multiplier, divider
// and square-root unit. Depends on lscf_pkg and lscf_ram.
module lscf_datapath #(
    parameter int MAX_POINTS = lscf_pkg::MAX_POINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lscf_pkg::t_dp_cmd                   i_cmd,
    output lscf_pkg::t_dp_stat                  o_stat,
    input  logic signed [lscf_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [lscf_pkg::COORD_W-1:0] i_point_y,
    output logic signed [lscf_pkg::COORD_W-1:0] o_center_x,
    output logic signed [lscf_pkg::COORD_W-1:0] o_center_y,
    output logic [lscf_pkg::RAD_W-1:0]          o_radius_out,
    output logic [lscf_pkg::STAT_W-1:0]         o_fit_status
);
    import lscf_pkg::*;

    localparam int LOG_N  = $clog2(MAX_POINTS + 1);
    localparam int CNT_W  = $clog2(MAX_POINTS + 2);
    localparam int SUM1_W = COORD_W + LOG_N;
    localparam int SUM2_W = 2 * COORD_W - 1 + LOG_N;
    localparam int SUM3_W = 3 * COORD_W - 1 + LOG_N;
    localparam int STEP_W = $clog2(DW);
    localparam int RF_AW  = $clog2(RF_DEPTH);

    // ---------------- accumulator ----------------
    logic [CNT_W-1:0]               r_cnt;
    logic                           cnt_full;
    logic                           r_s1_v;
    logic signed [COORD_W-1:0]      r_s1_x, r_s1_y;
    logic signed [2*COORD_W-1:0]    r_s1_xx, r_s1_yy, r_s1_xy;
    logic signed [2*COORD_W:0]      s1_r2;
    logic signed [3*COORD_W:0]      s1_xr2, s1_yr2;
    logic signed [SUM1_W-1:0]       r_sx, r_sy;
    logic signed [SUM2_W-1:0]       r_sxx, r_syy, r_sxy;
    logic signed [SUM3_W-1:0]       r_sxr2, r_syr2;
    logic                           sum_clr;

    assign cnt_full = (r_cnt >= CNT_W'(MAX_POINTS));
    assign sum_clr  = i_cmd.start && (i_cmd.uop.op == OP_END);
    assign s1_r2    = (2*COORD_W+1)'(r_s1_xx) + (2*COORD_W+1)'(r_s1_yy);
    assign s1_xr2   = r_s1_x * s1_r2;
    assign s1_yr2   = r_s1_y * s1_r2;

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_s1_x  <= i_point_x;
            r_s1_y  <= i_point_y;
            r_s1_xx <= i_point_x * i_point_x;
            r_s1_yy <= i_point_y * i_point_y;
            r_s1_xy <= i_point_x * i_point_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || sum_clr) begin
            r_cnt  <= '0;
            r_s1_v <= 1'b0;
            r_sx   <= '0;
            r_sy   <= '0;
            r_sxx  <= '0;
            r_syy  <= '0;
            r_sxy  <= '0;
            r_sxr2 <= '0;
            r_syr2 <= '0;
        end else begin
            r_s1_v <= i_cmd.acc && !cnt_full;
            if (i_cmd.acc) begin
                r_cnt <= cnt_full ? CNT_W'(MAX_POINTS + 1) : r_cnt + 1'b1;
            end
            if (r_s1_v) begin
                r_sx   <= r_sx + SUM1_W'(r_s1_x);
                r_sy   <= r_sy + SUM1_W'(r_s1_y);
                r_sxx  <= r_sxx + SUM2_W'(r_s1_xx);
                r_syy  <= r_syy + SUM2_W'(r_s1_yy);
                r_sxy  <= r_sxy + SUM2_W'(r_s1_xy);
                r_sxr2 <= r_sxr2 + SUM3_W'(s1_xr2);
                r_syr2 <= r_syr2 + SUM3_W'(s1_yr2);
            end
        end
    end

    // ---------------- solve engine ----------------
    logic [DW-1:0]  sum_sel;
    logic [DW-1:0]  rf_rdata;
    logic [DW-1:0]  r_a, r_b, r_p;
    t_op            r_op;
    logic [ARG_W-1:0] r_arg;
    logic           r_run, r_done, r_post;
    logic [STEP_W-1:0] r_step;

    logic [DW-1:0]  r_ma, r_mq, r_macc;
    logic [DW+MUL_DIGIT-1:0] mul_pp;
    logic [DW-1:0]  mul_acc_n;

    logic [DW-1:0]  r_dq, r_den;
    logic [DW:0]    r_rem, div_sh, div_nrem;
    logic           div_ge;
    logic           r_neg;
    logic [DW-1:0]  cen_mag, cen_lim, cen_v, cen_s;

    logic [SQ_W-1:0] r_sv, r_sres, r_sbit, sq_trial;
    logic            sq_ge;

    logic            r_thi, r_sing, r_negq;
    logic signed [COORD_W-1:0] r_cxr, r_cyr;
    logic [SQ_W-1:0] rad_r;
    logic [RAD_W-1:0] rad_fin;
    t_fit_status     fin_stat;

    always_comb begin
        case (i_cmd.uop.arg)
            SS_N:    sum_sel = DW'(r_cnt);
            SS_X:    sum_sel = DW'(r_sx);
            SS_Y:    sum_sel = DW'(r_sy);
            SS_XX:   sum_sel = DW'(r_sxx);
            SS_YY:   sum_sel = DW'(r_syy);
            SS_XY:   sum_sel = DW'(r_sxy);
            SS_XR2:  sum_sel = DW'(r_sxr2);
            SS_YR2:  sum_sel = DW'(r_syr2);
            default: sum_sel = '0;
        endcase
    end

    lscf_ram #(
        .WIDTH (DW),
        .DEPTH (RF_DEPTH)
    ) u_rf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.start && (i_cmd.uop.op == OP_WR)),
        .i_waddr (i_cmd.uop.arg[RF_AW-1:0]),
        .i_wdata (r_p),
        .i_raddr (i_cmd.uop.arg[RF_AW-1:0]),
        .o_rdata (rf_rdata)
    );

    assign mul_pp    = r_ma * r_mq[MUL_DIGIT-1:0];
    assign mul_acc_n = r_macc + mul_pp[DW-1:0];

    assign div_sh   = {r_rem[DW-1:0], r_dq[DW-1]};
    assign div_ge   = (div_sh >= {1'b0, r_den});
    assign div_nrem = div_ge ? div_sh - {1'b0, r_den} : div_sh;

    assign cen_mag = r_a[DW-1] ? -r_a : r_a;
    assign cen_lim = (r_arg == SH_NONE) ? CX_LIM : FX_LIM;
    assign cen_v   = (r_dq > cen_lim) ? cen_lim : r_dq;
    always_comb begin
        cen_s = r_neg ? -cen_v : cen_v;
        // the unshifted center clamps to the top of the output range
        if (r_arg == SH_NONE && !r_neg && cen_v > CX_MAX) begin
            cen_s = CX_MAX;
        end
    end

    assign sq_trial = r_sres + r_sbit;
    assign sq_ge    = (r_sv >= sq_trial);

    assign rad_r = (r_p[SQ_W-1:0] + RAD_HALF) >> GUARD;
    assign rad_fin = (r_thi || rad_r > RAD_MAX) ? RAD_MAX[RAD_W-1:0] : rad_r[RAD_W-1:0];

    always_comb begin
        if (r_cnt > CNT_W'(MAX_POINTS)) begin
            fin_stat = FIT_OVERFLOW;
        end else if (r_sing) begin
            fin_stat = FIT_SINGULAR;
        end else if (r_negq) begin
            fin_stat = FIT_NEGRAD;
        end else begin
            fin_stat = FIT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run        <= 1'b0;
            r_done       <= 1'b0;
            r_post       <= 1'b0;
            o_center_x   <= '0;
            o_center_y   <= '0;
            o_radius_out <= '0;
            o_fit_status <= FIT_OK;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_op   <= i_cmd.uop.op;
                r_arg  <= i_cmd.uop.arg;
                r_post <= 1'b0;
                case (i_cmd.uop.op)
                    OP_RDA, OP_RDB: begin
                        r_run <= 1'b1;
                    end
                    OP_SUMA:  begin r_a <= sum_sel; r_done <= 1'b1; end
                    OP_SUMB:  begin r_b <= sum_sel; r_done <= 1'b1; end
                    OP_MOVA:  begin r_a <= r_p; r_done <= 1'b1; end
                    OP_MOVB:  begin r_b <= r_p; r_done <= 1'b1; end
                    OP_ADD:   begin r_p <= r_a + r_b; r_done <= 1'b1; end
                    OP_SUB:   begin r_p <= r_a - r_b; r_done <= 1'b1; end
                    OP_SHL:   begin r_p <= r_a << i_cmd.uop.arg; r_done <= 1'b1; end
                    OP_WR:    r_done <= 1'b1;
                    OP_FLAGD: begin r_sing <= (r_p == '0) || r_p[DW-1]; r_done <= 1'b1; end
                    OP_FLAGQ: begin r_negq <= r_p[DW-1]; r_done <= 1'b1; end
                    OP_SETX:  begin r_cxr <= r_p[COORD_W-1:0]; r_done <= 1'b1; end
                    OP_SETY:  begin r_cyr <= r_p[COORD_W-1:0]; r_done <= 1'b1; end
                    OP_MUL: begin
                        r_ma   <= r_a;
                        r_mq   <= r_b;
                        r_macc <= '0;
                        r_step <= STEP_W'(MUL_STEPS - 1);
                        r_run  <= 1'b1;
                    end
                    OP_DIV: begin
                        r_dq   <= r_a;
                        r_den  <= r_b;
                        r_rem  <= '0;
                        r_step <= STEP_W'(DW - 1);
                        r_run  <= 1'b1;
                    end
                    OP_CEN: begin
                        // round half away: (|n| << sh + d) / 2d
                        r_dq   <= (cen_mag << i_cmd.uop.arg) + r_b;
                        r_den  <= r_b << 1;
                        r_neg  <= r_a[DW-1];
                        r_rem  <= '0;
                        r_step <= STEP_W'(DW - 1);
                        r_run  <= 1'b1;
                    end
                    OP_SQRT: begin
                        r_thi  <= |r_p[DW-1:SQ_W];
                        r_sv   <= r_p[SQ_W-1:0];
                        r_sres <= '0;
                        r_sbit <= SQ_W'(1) << (SQ_W - 2);
                        r_step <= STEP_W'(SQRT_STEPS - 1);
                        r_run  <= 1'b1;
                    end
                    OP_END: begin
                        o_fit_status <= fin_stat;
                        o_center_x   <= (fin_stat == FIT_OK || fin_stat == FIT_NEGRAD)
                                        ? r_cxr : '0;
                        o_center_y   <= (fin_stat == FIT_OK || fin_stat == FIT_NEGRAD)
                                        ? r_cyr : '0;
                        o_radius_out <= (fin_stat == FIT_OK) ? rad_fin : '0;
                        r_done       <= 1'b1;
                    end
                    default: r_done <= 1'b1;
                endcase
            end else if (r_run) begin
                case (r_op)
                    OP_RDA: begin r_a <= rf_rdata; r_run <= 1'b0; r_done <= 1'b1; end
                    OP_RDB: begin r_b <= rf_rdata; r_run <= 1'b0; r_done <= 1'b1; end
                    OP_MUL: begin
                        r_macc <= mul_acc_n;
                        r_ma   <= r_ma << MUL_DIGIT;
                        r_mq   <= r_mq >> MUL_DIGIT;
                        r_step <= r_step - 1'b1;
                        if (r_step == '0) begin
                            r_p    <= mul_acc_n;
                            r_run  <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                    OP_DIV, OP_CEN: begin
                        if (r_post) begin
                            r_p    <= cen_s;
                            r_run  <= 1'b0;
                            r_done <= 1'b1;
                        end else begin
                            r_rem  <= div_nrem;
                            r_dq   <= {r_dq[DW-2:0], div_ge};
                            r_step <= r_step - 1'b1;
                            if (r_step == '0) begin
                                if (r_op == OP_DIV) begin
                                    r_p    <= {r_dq[DW-2:0], div_ge};
                                    r_run  <= 1'b0;
                                    r_done <= 1'b1;
                                end else begin
                                    r_post <= 1'b1;
                                end
                            end
                        end
                    end
                    OP_SQRT: begin
                        r_sv   <= sq_ge ? r_sv - sq_trial : r_sv;
                        r_sres <= sq_ge ? (r_sres >> 1) + r_sbit : r_sres >> 1;
                        r_sbit <= r_sbit >> 2;
                        r_step <= r_step - 1'b1;
                        if (r_step == '0) begin
                            r_p    <= DW'(sq_ge ? (r_sres >> 1) + r_sbit : r_sres >> 1);
                            r_run  <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                    default: begin
                        r_run  <= 1'b0;
                        r_done <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.acc_busy = r_s1_v;
endmodule

// ===== rtl/core/lscf_ctrl.sv =====
// Controller: point handshake, microprogram sequencer for the solve and
// result handshake. Depends on lscf_pkg.
module lscf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lscf_pkg::t_dp_cmd  o_cmd,
    input  lscf_pkg::t_dp_stat i_stat
);
    import lscf_pkg::*;

    localparam int UCODE_LEN = 146;
    localparam int PC_W      = $clog2(UCODE_LEN);

    // Solve program: eliminate c, build the 2x2 system, then center and radius.
    localparam t_uop UCODE [UCODE_LEN] = '{
        // sr2 = sxx + syy
        '{OP_SUMA, SS_XX}, '{OP_SUMB, SS_YY}, '{OP_ADD, ARG_NONE}, '{OP_WR, RA_SR2},
        // cxx = n*sxx - sx*sx
        '{OP_SUMA, SS_N}, '{OP_SUMB, SS_XX}, '{OP_MUL, ARG_NONE}, '{OP_WR, RA_T1},
        '{OP_SUMA, SS_X}, '{OP_SUMB, SS_X}, '{OP_MUL, ARG_NONE}, '{OP_MOVB, ARG_NONE},
        '{OP_RDA, RA_T1}, '{OP_SUB, ARG_NONE}, '{OP_WR, RA_CXX},
        // cyy = n*syy - sy*sy
        '{OP_SUMA, SS_N}, '{OP_SUMB, SS_YY}, '{OP_MUL, ARG_NONE}, '{OP_WR, RA_T1},
        '{OP_SUMA, SS_Y}, '{OP_SUMB, SS_Y}, '{OP_MUL, ARG_NONE}, '{OP_MOVB, ARG_NONE},
        '{OP_RDA, RA_T1}, '{OP_SUB, ARG_NONE}, '{OP_WR, RA_CYY},
        // cxy = n*sxy - sx*sy
        '{OP_SUMA, SS_N}, '{OP_SUMB, SS_XY}, '{OP_MUL, ARG_NONE}, '{OP_WR, RA_T1},
        '{OP_SUMA, SS_X}, '{OP_SUMB, SS_Y}, '{OP_MUL, ARG_NONE}, '{OP_MOVB, ARG_NONE},
        '{OP_RDA, RA_T1}, '{OP_SUB, ARG_NONE}, '{OP_WR, RA_CXY},
        // px = sx*sr2 - n*sxr2
        '{OP_SUMA, SS_N}, '{OP_SUMB, SS_XR2}, '{OP_MUL, ARG_NONE}, '{OP_WR, RA_T1},
        '{OP_SUMA, SS_X}, '{OP_RDB, RA_SR2}, '{OP_MUL, ARG_NONE}, '{OP_MOVA, ARG_NONE},
        '{OP_RDB, RA_T1}, '{OP_SUB, ARG_NONE}, '{OP_WR, RA_PX},
        // py = sy*sr2 - n*syr2
        '{OP_SUMA, SS_N}, '{OP_SUMB, SS_YR2}, '{OP_MUL, ARG_NONE}, '{OP_WR, RA_T1},
        '{OP_SUMA, SS_Y}, '{OP_RDB, RA_SR2}, '{OP_MUL, ARG_NONE}, '{OP_MOVA, ARG_NONE},
        '{OP_RDB, RA_T1}, '{OP_SUB, ARG_NONE}, '{OP_WR, RA_PY},
        // d = cxx*cyy - cxy*cxy
        '{OP_RDA, RA_CXY}, '{OP_RDB, RA_CXY}, '{OP_MUL, ARG_NONE}, '{OP_WR, RA_T1},
        '{OP_RDA, RA_CXX}, '{OP_RDB, RA_CYY}, '{OP_MUL, ARG_NONE}, '{OP_MOVA, ARG_NONE},
        '{OP_RDB, RA_T1}, '{OP_SUB, ARG_NONE}, '{OP_WR, RA_D}, '{OP_FLAGD, ARG_NONE},
        // nx = py*cxy - px*cyy
        '{OP_RDA, RA_PX}, '{OP_RDB, RA_CYY}, '{OP_MUL, ARG_NONE}, '{OP_WR, RA_T1},
        '{OP_RDA, RA_PY}, '{OP_RDB, RA_CXY}, '{OP_MUL, ARG_NONE}, '{OP_MOVA, ARG_NONE},
        '{OP_RDB, RA_T1}, '{OP_SUB, ARG_NONE}, '{OP_WR, RA_NX},
        // ny = px*cxy - py*cxx
        '{OP_RDA, RA_PY}, '{OP_RDB, RA_CXX}, '{OP_MUL, ARG_NONE}, '{OP_WR, RA_T1},
        '{OP_RDA, RA_PX}, '{OP_RDB, RA_CXY}, '{OP_MUL, ARG_NONE}, '{OP_MOVA, ARG_NONE},
        '{OP_RDB, RA_T1}, '{OP_SUB, ARG_NONE}, '{OP_WR, RA_NY},
        // centers, fine and output precision
        '{OP_RDA, RA_NX}, '{OP_RDB, RA_D}, '{OP_CEN, SH_G}, '{OP_WR, RA_FX},
        '{OP_CEN, SH_NONE}, '{OP_SETX, ARG_NONE},
        '{OP_RDA, RA_NY}, '{OP_RDB, RA_D}, '{OP_CEN, SH_G}, '{OP_WR, RA_FY},
        '{OP_CEN, SH_NONE}, '{OP_SETY, ARG_NONE},
        // t1 = (fx*sx + fy*sy) << (G+1)
        '{OP_RDA, RA_FX}, '{OP_SUMB, SS_X}, '{OP_MUL, ARG_NONE}, '{OP_WR, RA_T1},
        '{OP_RDA, RA_FY}, '{OP_SUMB, SS_Y}, '{OP_MUL, ARG_NONE}, '{OP_MOVA, ARG_NONE},
        '{OP_RDB, RA_T1}, '{OP_ADD, ARG_NONE}, '{OP_MOVA, ARG_NONE}, '{OP_SHL, SH_G1},
        '{OP_WR, RA_T1},
        // q = (sr2 << 2G) - t1
        '{OP_RDA, RA_SR2}, '{OP_SHL, SH_2G}, '{OP_MOVA, ARG_NONE}, '{OP_RDB, RA_T1},
        '{OP_SUB, ARG_NONE}, '{OP_WR, RA_Q},
        // q += n*(fx*fx + fy*fy)
        '{OP_RDA, RA_FX}, '{OP_RDB, RA_FX}, '{OP_MUL, ARG_NONE}, '{OP_WR, RA_T1},
        '{OP_RDA, RA_FY}, '{OP_RDB, RA_FY}, '{OP_MUL, ARG_NONE}, '{OP_MOVA, ARG_NONE},
        '{OP_RDB, RA_T1}, '{OP_ADD, ARG_NONE}, '{OP_MOVA, ARG_NONE}, '{OP_SUMB, SS_N},
        '{OP_MUL, ARG_NONE}, '{OP_MOVA, ARG_NONE}, '{OP_RDB, RA_Q}, '{OP_ADD, ARG_NONE},
        '{OP_FLAGQ, ARG_NONE},
        // radius = isqrt(q / n), then emit
        '{OP_MOVA, ARG_NONE}, '{OP_SUMB, SS_N}, '{OP_DIV, ARG_NONE}, '{OP_SQRT, ARG_NONE},
        '{OP_END, ARG_NONE}
    };

    typedef enum logic [4:0] {
        S_ACC   = 5'b00001,
        S_DRAIN = 5'b00010,
        S_ISSUE = 5'b00100,
        S_WAIT  = 5'b01000,
        S_OUT   = 5'b10000
    } t_ctrl_state;

    t_ctrl_state     r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    t_uop            cur_uop;

    assign cur_uop = UCODE[r_pc];

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        case (r_state)
            S_ACC: begin
                if (i_in_valid && i_in_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // let the last point reach the sums
                if (!i_stat.acc_busy) begin
                    n_state = S_ISSUE;
                    n_pc    = '0;
                end
            end
            S_ISSUE: n_state = S_WAIT;
            S_WAIT: begin
                if (i_stat.done) begin
                    if (cur_uop.op == OP_END) begin
                        n_state = S_OUT;
                    end else begin
                        n_pc    = r_pc + 1'b1;
                        n_state = S_ISSUE;
                    end
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_ACC;
                end
            end
            default: n_state = S_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    assign o_in_ready  = (r_state == S_ACC);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.start = (r_state == S_ISSUE);
    assign o_cmd.acc   = (r_state == S_ACC) && i_in_valid;
    assign o_cmd.uop   = cur_uop;
endmodule

// ===== rtl/core/least_squares_circle_fit.sv =====
// Algebraic least-squares circle fit. Points stream in one per clock and
// update the running sums through a one-stage product pipeline; the point
// flagged last closes the set. A microprogrammed solve then runs on one shared
// 8-bit-digit multiplier, a bit-serial divider (one quotient bit a cycle) and
// a 32-step square-root unit; about half of the solve time goes to the four
// center divisions and the mean division. One result follows each set; no
// points are taken from the last point until that result is transferred. The
// sums clear once the result is formed. Depends on lscf_pkg, the channel
// interfaces, lscf_ctrl and lscf_datapath.
module least_squares_circle_fit #(
    parameter int MAX_POINTS = lscf_pkg::MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lscf_point_if.sink  i_point,
    lscf_fit_if.source  o_fit
);
    import lscf_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    lscf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_point.valid),
        .i_in_last   (i_point.last_point),
        .o_in_ready  (i_point.ready),
        .o_out_valid (o_fit.valid),
        .i_out_ready (o_fit.ready),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat)
    );

    lscf_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_point_x    (i_point.point_x),
        .i_point_y    (i_point.point_y),
        .o_center_x   (o_fit.center_x),
        .o_center_y   (o_fit.center_y),
        .o_radius_out (o_fit.radius_out),
        .o_fit_status (o_fit.fit_status)
    );
endmodule
